// ----- sv/round_robin_process_queue_macros.svh -----
// Assertion macros shared by the round-robin process queue RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ROUND_ROBIN_PROCESS_QUEUE_MACROS_SVH
`define ROUND_ROBIN_PROCESS_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF
// a holds at every edge out of reset
`define RRPQ_ASSERT(lbl, clk, rst_n, a) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a)) \
    else $error("rrpq assertion failed");
// a implies c at the same edge
`define RRPQ_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("rrpq assertion failed");
// a implies c at the next edge
`define RRPQ_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("rrpq assertion failed");
`else
`define RRPQ_ASSERT(lbl, clk, rst_n, a)
`define RRPQ_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define RRPQ_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif

`endif

// ----- sv/rrpq_pkg.sv -----
// Package for the round-robin process queue: widths, codes and cell command type.
// No dependencies.
`default_nettype none
package rrpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 16;
  localparam int JT_W        = 16;
  localparam int TM_W        = 17;
  localparam int QUANT_W     = 16;
  localparam int STAT_W      = 3;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_ROTATED   = 3'd4,
    ST_REMOVED   = 3'd5
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic            shift;   // every cell takes its upper neighbour
    logic            rotate;  // with shift: last occupied cell takes the broadcast job
    logic            insert;  // first free cell takes the broadcast job
    logic [ID_W-1:0] id;      // broadcast id, also the compare key
    logic [TM_W-1:0] tm;      // broadcast remaining time
  } cell_cmd_t;

endpackage
`default_nettype wire

// ----- sv/round_robin_process_queue.sv -----
// Round-robin process queue: a chain of job cells with the head at cell 0.
// The result is registered from the request register once the result slot is free.
// One request at a time: request register, then one chain update, before the next is taken.
// A waiting result does not block the next request's capture; its update waits for the slot.
// Reset (synchronous, rst_n low): queue empty, quantum 1; cell contents are left as they are.
`default_nettype none
module round_robin_process_queue (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_req_type,
  input  wire logic [rrpq_pkg::ID_W-1:0]     in_job_id,
  input  wire logic [rrpq_pkg::JT_W-1:0]     in_job_time,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [rrpq_pkg::STAT_W-1:0]   out_status,
  output logic      [rrpq_pkg::ID_W-1:0]     out_result_id,
  output logic signed [rrpq_pkg::TM_W-1:0]   out_result_time,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rrpq_pkg::QUANT_W-1:0]  cfg_quantum
);
  import rrpq_pkg::*;

  // Chain view: cell i holds the i-th job in service order.
  // occ: cell holds a job; at_tail: first free cell (insert target);
  // at_last: last occupied cell (where a rotated head lands).
  cell_cmd_t             cmd;
  logic [CNT_W-1:0]      count;
  logic [QUEUE_DEPTH-1:0] occ, at_tail, at_last, match;
  logic [ID_W-1:0]       cid [QUEUE_DEPTH];
  logic [TM_W-1:0]       ctm [QUEUE_DEPTH];
  logic [ID_W-1:0]       nid [QUEUE_DEPTH];
  logic [TM_W-1:0]       ntm [QUEUE_DEPTH];
  logic [TM_W-1:0]       rtm;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      assign occ[gi]     = (count > CNT_W'(gi));
      assign at_tail[gi] = (count == CNT_W'(gi));
      assign at_last[gi] = (count == CNT_W'(gi + 1));

      // top cell has no upper neighbour; what it takes on a shift is never read
      if (gi == QUEUE_DEPTH - 1) begin : g_top
        assign nid[gi] = cmd.id;
        assign ntm[gi] = cmd.tm;
      end else begin : g_mid
        assign nid[gi] = cid[gi+1];
        assign ntm[gi] = ctm[gi+1];
      end

      rrpq_cell u_cell (
        .clk     (clk),
        .cmd     (cmd),
        .occ     (occ[gi]),
        .at_tail (at_tail[gi]),
        .at_last (at_last[gi]),
        .nb_id   (nid[gi]),
        .nb_tm   (ntm[gi]),
        .id      (cid[gi]),
        .tm      (ctm[gi]),
        .match   (match[gi])
      );
    end
  endgenerate

  // Duplicate search: every occupied cell compares its id with the key at once
  rrpq_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_job_id       (in_job_id),
    .in_job_time     (in_job_time),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_result_id   (out_result_id),
    .out_result_time (rtm),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_quantum     (cfg_quantum),
    .head_id         (cid[0]),
    .head_tm         (ctm[0]),
    .dup             (|match),
    .cmd             (cmd),
    .count           (count)
  );

  assign out_result_time = $signed(rtm);

endmodule
`default_nettype wire

// ----- sv/rrpq_cell.sv -----
// One slot of the job chain: holds an id and a remaining time.
// Depends on rrpq_pkg.
`default_nettype none
module rrpq_cell (
  input  wire logic                     clk,
  input  wire rrpq_pkg::cell_cmd_t      cmd,
  input  wire logic                     occ,
  input  wire logic                     at_tail,
  input  wire logic                     at_last,
  input  wire logic [rrpq_pkg::ID_W-1:0] nb_id,
  input  wire logic [rrpq_pkg::TM_W-1:0] nb_tm,
  output logic      [rrpq_pkg::ID_W-1:0] id,
  output logic      [rrpq_pkg::TM_W-1:0] tm,
  output logic                          match
);
  import rrpq_pkg::*;

  logic [ID_W-1:0] id_r, id_nxt;
  logic [TM_W-1:0] tm_r, tm_nxt;

  always_comb begin
    id_nxt = id_r;
    tm_nxt = tm_r;
    if (cmd.shift) begin
      if (cmd.rotate && at_last) begin
        id_nxt = cmd.id;
        tm_nxt = cmd.tm;
      end else begin
        id_nxt = nb_id;
        tm_nxt = nb_tm;
      end
    end else if (cmd.insert && at_tail) begin
      id_nxt = cmd.id;
      tm_nxt = cmd.tm;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
    tm_r <= tm_nxt;
  end

  assign id    = id_r;
  assign tm    = tm_r;
  assign match = occ && (id_r == cmd.id);

endmodule
`default_nettype wire

// ----- sv/rrpq_ctrl.sv -----
// Sequencer of the round-robin process queue: request and result registers,
// job count, quantum register and the cell commands. Depends on rrpq_pkg.
`default_nettype none
`include "round_robin_process_queue_macros.svh"
module rrpq_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_req_type,
  input  wire logic [rrpq_pkg::ID_W-1:0]     in_job_id,
  input  wire logic [rrpq_pkg::JT_W-1:0]     in_job_time,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [rrpq_pkg::STAT_W-1:0]   out_status,
  output logic      [rrpq_pkg::ID_W-1:0]     out_result_id,
  output logic      [rrpq_pkg::TM_W-1:0]     out_result_time,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rrpq_pkg::QUANT_W-1:0]  cfg_quantum,
  input  wire logic [rrpq_pkg::ID_W-1:0]     head_id,
  input  wire logic [rrpq_pkg::TM_W-1:0]     head_tm,
  input  wire logic                          dup,
  output rrpq_pkg::cell_cmd_t                cmd,
  output logic      [rrpq_pkg::CNT_W-1:0]    count
);
  import rrpq_pkg::*;

  fsm_t                state_r, state_nxt;
  logic                req_r, req_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [JT_W-1:0]     jt_r, jt_nxt;
  logic [QUANT_W-1:0]  quantum_r, quantum_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             status_r, status_nxt;
  logic [ID_W-1:0]     rid_r, rid_nxt;
  logic [TM_W-1:0]     rtm_r, rtm_nxt;

  logic                out_free;
  logic                fire;
  logic [TM_W:0]       diff;
  logic [TM_W-1:0]     new_tm;
  logic                head_pos;
  logic                full;

  assign cfg_ready   = 1'b1;
  assign quantum_nxt = cfg_valid ? cfg_quantum : quantum_r;

  assign out_free = !out_valid_r || out_ready;
  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  // head time minus quantum; the result fits the time width whenever it is used (positive head)
  assign diff     = {head_tm[TM_W-1], head_tm} - {2'b00, quantum_r};
  assign new_tm   = diff[TM_W-1:0];
  assign head_pos = !head_tm[TM_W-1] && (|head_tm);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    id_nxt        = id_r;
    jt_nxt        = jt_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    rid_nxt       = rid_r;
    rtm_nxt       = rtm_r;
    in_ready      = 1'b0;
    fire          = 1'b0;
    cmd.shift     = 1'b0;
    cmd.rotate    = 1'b0;
    cmd.insert    = 1'b0;
    cmd.id        = req_r ? head_id : id_r;
    cmd.tm        = req_r ? new_tm : {1'b0, jt_r};

    case (state_r)
      FSM_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt   = in_req_type;
          id_nxt    = in_job_id;
          jt_nxt    = in_job_time;
          state_nxt = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (out_free) begin
          fire          = 1'b1;
          state_nxt     = FSM_IDLE;
          out_valid_nxt = 1'b1;
          rid_nxt       = '0;
          rtm_nxt       = '0;
          if (!req_r) begin
            if (dup) begin
              status_nxt = ST_DUPLICATE;
            end else if (full) begin
              status_nxt = ST_FULL;
            end else begin
              status_nxt = ST_INSERTED;
              rid_nxt    = id_r;
              cmd.insert = 1'b1;
              count_nxt  = count_r + CNT_W'(1);
            end
          end else if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else if (head_pos) begin
            status_nxt = ST_ROTATED;
            rid_nxt    = head_id;
            rtm_nxt    = new_tm;
            cmd.shift  = 1'b1;
            cmd.rotate = 1'b1;
          end else begin
            status_nxt = ST_REMOVED;
            rid_nxt    = head_id;
            cmd.shift  = 1'b1;
            count_nxt  = count_r - CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      quantum_r   <= QUANT_W'(1);
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      quantum_r   <= quantum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    id_r     <= id_nxt;
    jt_r     <= jt_nxt;
    status_r <= status_nxt;
    rid_r    <= rid_nxt;
    rtm_r    <= rtm_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_result_id   = rid_r;
  assign out_result_time = rtm_r;
  assign count           = count_r;

  `RRPQ_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(QUEUE_DEPTH))
  `RRPQ_ASSERT_IMP(a_ins_not_full, clk, rst_n, fire && status_nxt == ST_INSERTED, !full)
  `RRPQ_ASSERT_NXT(a_rot_keeps_count, clk, rst_n, fire && status_nxt == ST_ROTATED,
                   count_r == $past(count_r))
  `RRPQ_ASSERT_NXT(a_rem_drops_count, clk, rst_n, fire && status_nxt == ST_REMOVED,
                   count_r == $past(count_r) - CNT_W'(1))
  `RRPQ_ASSERT_IMP(a_fire_needs_room, clk, rst_n, fire, state_r == FSM_EXEC && out_free)

endmodule
`default_nettype wire

// ----- tb/sv/rrpq_tb_pkg.sv -----
// Request codes shared by the round-robin process queue testbench files.
// Depends on nothing; compiled before the checker and the testbench top.
package rrpq_tb_pkg;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_TICK   = 1'b1
  } req_t;

endpackage

// ----- tb/sv/rrpq_checker.sv -----
// Checker for the round-robin process queue: watches the request, result and
// quantum channels, keeps its own job queue and compares every result beat.
// Depends on rrpq_pkg and rrpq_tb_pkg.
module rrpq_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic                             in_req_type,
  input  logic [rrpq_pkg::ID_W-1:0]        in_job_id,
  input  logic [rrpq_pkg::JT_W-1:0]        in_job_time,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [rrpq_pkg::STAT_W-1:0]      out_status,
  input  logic [rrpq_pkg::ID_W-1:0]        out_result_id,
  input  logic signed [rrpq_pkg::TM_W-1:0] out_result_time,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [rrpq_pkg::QUANT_W-1:0]     cfg_quantum,
  output int                               fail_count,
  output int                               outstanding,
  output int                               results_seen
);
  import rrpq_pkg::*;
  import rrpq_tb_pkg::*;

  typedef struct packed {
    status_t                status;
    logic [ID_W-1:0]        id;
    logic signed [TM_W-1:0] tm;
  } job_result_t;

  // predicted queue: circular store, head slot, occupancy
  logic [ID_W-1:0]        slot_id [QUEUE_DEPTH];
  logic signed [TM_W-1:0] slot_tm [QUEUE_DEPTH];
  int                     head_slot;
  int                     jobs_held;
  logic [QUANT_W-1:0]     slice;

  job_result_t            pending_results[$];

  initial begin
    fail_count   = 0;
    results_seen = 0;
    outstanding  = 0;
  end

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= 20) $display("mismatch: %s", msg);
  endtask

  function automatic job_result_t serve_request(input logic req, input logic [ID_W-1:0] id,
                                                input logic [JT_W-1:0] jt);
    job_result_t r;
    bit          seen;
    int          h;
    int          tail;
    int          ht;
    int          nt;
    r    = '0;
    seen = 0;
    if (req == REQ_INSERT) begin
      for (int k = 0; k < jobs_held; k++)
        if (slot_id[(head_slot + k) % QUEUE_DEPTH] == id) seen = 1;
      // duplicate wins over full
      if (seen) begin
        r.status = ST_DUPLICATE;
      end else if (jobs_held >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        tail          = (head_slot + jobs_held) % QUEUE_DEPTH;
        slot_id[tail] = id;
        slot_tm[tail] = {1'b0, jt};
        jobs_held++;
        r.status = ST_INSERTED;
        r.id     = id;
      end
    end else if (jobs_held == 0) begin
      r.status = ST_EMPTY;
    end else begin
      h  = head_slot;
      ht = slot_tm[h];
      r.id = slot_id[h];
      if (ht > 0) begin
        nt = ht - int'(slice);
        if (jobs_held > 1) begin
          tail          = (head_slot + jobs_held) % QUEUE_DEPTH;
          slot_id[tail] = slot_id[h];
          slot_tm[tail] = nt[TM_W-1:0];
          head_slot     = (head_slot + 1) % QUEUE_DEPTH;
        end else begin
          // lone job keeps the head
          slot_tm[h] = nt[TM_W-1:0];
        end
        r.status = ST_ROTATED;
        r.tm     = nt[TM_W-1:0];
      end else begin
        head_slot = (head_slot + 1) % QUEUE_DEPTH;
        jobs_held--;
        r.status = ST_REMOVED;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    job_result_t want;
    if (!rst_n) begin
      head_slot = 0;
      jobs_held = 0;
      slice     = 16'd1;
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) slice = cfg_quantum;
      // result beat first: it always belongs to an older request
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report($sformatf("result beat with nothing pending (status %0d id %0d)",
                           out_status, out_result_id));
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status)
            report($sformatf("status got %0d want %0d", out_status, want.status));
          if (out_result_id !== want.id)
            report($sformatf("result_id got %0d want %0d", out_result_id, want.id));
          if (out_result_time !== want.tm)
            report($sformatf("result_time got %0d want %0d", out_result_time, want.tm));
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(serve_request(in_req_type, in_job_id, in_job_time));
    end
    outstanding <= pending_results.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench top for the round-robin process queue: clock, reset, stimulus
// and verdict. Depends on rrpq_pkg, rrpq_tb_pkg and the rrpq_checker module.
module tb_top;
  import rrpq_pkg::*;
  import rrpq_tb_pkg::*;

  localparam int GAP_MAX     = 12;   // longest idle burst on either side
  localparam int HOLD_CYCLES = 300;  // long result hold-off, fills the block
  localparam int PHASE_ITEMS = 175;
  localparam int N_PHASES    = 6;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic                   in_req_type;
  logic [ID_W-1:0]        in_job_id;
  logic [JT_W-1:0]        in_job_time;
  logic                   out_valid;
  logic                   out_ready;
  logic [STAT_W-1:0]      out_status;
  logic [ID_W-1:0]        out_result_id;
  logic signed [TM_W-1:0] out_result_time;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [QUANT_W-1:0]     cfg_quantum;

  int fail_count;
  int outstanding;
  int results_seen;

  // gaps_on and hold_req are shared between the sender and the receiver process
  bit gaps_on   = 1;
  bit hold_req  = 0;
  int items_sent = 0;
  int cfg_writes = 0;

  round_robin_process_queue DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_job_id       (in_job_id),
    .in_job_time     (in_job_time),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_result_id   (out_result_id),
    .out_result_time (out_result_time),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_quantum     (cfg_quantum)
  );

  rrpq_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_job_id       (in_job_id),
    .in_job_time     (in_job_time),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_result_id   (out_result_id),
    .out_result_time (out_result_time),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_quantum     (cfg_quantum),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_seen    (results_seen)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Send one request beat. Valid stays high after acceptance unless the next
  // call opens an idle burst, so back-to-back beats never drop valid.
  task automatic send_item(input req_t req, input logic [ID_W-1:0] id,
                           input logic [JT_W-1:0] jt);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_job_id   <= id;
    in_job_time <= jt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_insert(input logic [ID_W-1:0] id, input logic [JT_W-1:0] jt);
    send_item(REQ_INSERT, id, jt);
  endtask

  // tick payload is don't-care, so it is random to toggle the bits
  task automatic send_tick();
    send_item(REQ_TICK, ID_W'($urandom), JT_W'($urandom));
  endtask

  // Stop offering, then wait for every pending result. outstanding is a
  // registered copy, so the wait runs on past zero to cover the final beat.
  task automatic wait_queue_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_quantum(input logic [QUANT_W-1:0] q);
    cfg_valid   <= 1'b1;
    cfg_quantum <= q;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
    @(posedge clk);
  endtask

  // Random request: inserts draw ids mostly from a narrow pool so duplicates
  // and a full queue come up often; now and then a full-width id or time.
  task automatic send_random(input int ins_pct, input int time_span);
    logic [ID_W-1:0] id;
    logic [JT_W-1:0] jt;
    if ($urandom_range(0, 99) < ins_pct) begin
      id = ($urandom_range(0, 7) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 40));
      jt = ($urandom_range(0, 7) == 0) ? JT_W'($urandom) : JT_W'($urandom_range(0, time_span));
      send_insert(id, jt);
    end else begin
      send_tick();
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Run limit, well above the slowest legal run.
  initial begin
    #2000000;
    $display("FAIL round_robin_process_queue");
    $finish;
  end

  initial begin
    logic [QUANT_W-1:0] slice;
    int                 ins_pct;
    int                 span;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_req_type <= REQ_INSERT;
    in_job_id   <= '0;
    in_job_time <= '0;
    cfg_valid   <= 1'b0;
    cfg_quantum <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, quantum at its reset value of 1
    send_tick();                        // tick with nothing queued
    send_insert(16'h0000, 16'h0000);    // lowest id, zero time
    send_insert(16'hFFFF, 16'hFFFF);    // highest id, largest time
    send_insert(16'h0000, 16'h1234);    // duplicate id
    send_tick();                        // zero time: removed
    send_tick();                        // lone job: served, stays at head
    wait_queue_idle();

    // --- directed, largest quantum: fill the queue and go negative
    write_quantum(16'hFFFF);
    for (int k = 1; k <= QUEUE_DEPTH - 1; k++)
      send_insert(ID_W'(k), JT_W'(k));
    send_insert(16'h1234, 16'h0005);    // queue full
    send_insert(16'hFFFF, 16'h0001);    // duplicate into a full queue
    send_tick();                        // 65534 - 65535 = -1
    send_tick();                        // 1 - 65535, the lowest reachable time
    wait_queue_idle();

    // --- random phases; quantum swept through zero, one, the maximum and others
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       slice = 16'd0;         // positive jobs rotate unchanged
        1:       slice = 16'hFFFF;
        2:       slice = 16'd1;
        3:       slice = QUANT_W'($urandom_range(2, 9));
        4:       slice = QUANT_W'($urandom);
        default: slice = 16'd1;
      endcase
      write_quantum(slice);
      span = (slice == 0) ? 3 : 10;
      if (p == 2) hold_req = 1;         // sender keeps offering during the hold-off
      if (p == N_PHASES - 1) gaps_on = 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // fill in the first half, drain in the second
        ins_pct = (i < PHASE_ITEMS / 2) ? 70 : 35;
        send_random(ins_pct, span);
      end
      wait_queue_idle();
    end

    repeat (8) @(posedge clk);
    $display("covered %0d requests and %0d results over %0d quantum writes",
             items_sent, results_seen, cfg_writes);
    $display("with idle bursts on both sides and a %0d-cycle result hold-off", HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("PASS round_robin_process_queue");
    end else begin
      $display("FAIL round_robin_process_queue");
    end
    $finish;
  end

endmodule
